// ===== sv/brq_pkg.sv =====
package brq_pkg;

  // Physical store size in bytes; a power of two.
  localparam int STORE_BYTES = 4096;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int PTR_W       = 12;
  localparam int CAP_W       = 12;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4088);

  localparam int NUM_BANKS  = 8;
  localparam int LANE_W     = $clog2(NUM_BANKS);
  localparam int BANK_ROWS  = STORE_BYTES / NUM_BANKS;
  localparam int ROW_W      = ADDR_W - LANE_W;
  localparam int LEN_W      = LANE_W + 1;
  localparam int SIZE_W     = 2;
  localparam int DATA_W     = 64;

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_t;

  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] row;
    logic [7:0]       wbyte;
  } lane_t;

  typedef struct packed {
    logic [LANE_W-1:0] a0;
    logic [SIZE_W-1:0] size;
  } pop_info_t;

  function automatic logic [LEN_W-1:0] size_len(input logic [SIZE_W-1:0] size);
    size_len = LEN_W'(1) << size;
  endfunction

endpackage

// ===== sv/brq_ifs.sv =====
interface brq_req_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [brq_pkg::SIZE_W-1:0]    access_size;
  logic [brq_pkg::DATA_W-1:0]    push_data;

  modport source (output valid, output func, output access_size, output push_data,
                  input ready);
  modport sink   (input valid, input func, input access_size, input push_data,
                  output ready);
endinterface

interface brq_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [brq_pkg::DATA_W-1:0] pop_data;

  modport source (output valid, output pop_data, input ready);
  modport sink   (input valid, input pop_data, output ready);
endinterface

// ===== sv/brq_lane_map.sv =====
module brq_lane_map (
  input  logic [brq_pkg::PTR_W-1:0]  base,
  input  logic [brq_pkg::SIZE_W-1:0] size,
  input  logic [brq_pkg::DATA_W-1:0] data,
  output brq_pkg::lane_t             lanes [brq_pkg::NUM_BANKS]
);

  logic [brq_pkg::ADDR_W-1:0] addr;
  logic [brq_pkg::LANE_W-1:0] a0;
  logic [brq_pkg::ROW_W-1:0]  row0;
  logic [brq_pkg::LEN_W-1:0]  len;

  assign addr = brq_pkg::ADDR_W'(base);
  assign a0   = addr[brq_pkg::LANE_W-1:0];
  assign row0 = addr[brq_pkg::ADDR_W-1:brq_pkg::LANE_W];
  assign len  = brq_pkg::size_len(size);

  // Bank b holds the byte at offset (b - a0) mod NUM_BANKS of the access. When
  // the access crosses a row boundary the low banks take the following row.
  always_comb begin
    logic [brq_pkg::LANE_W-1:0] off;
    logic [brq_pkg::LEN_W-1:0]  pos;
    for (int b = 0; b < brq_pkg::NUM_BANKS; b++) begin
      off = brq_pkg::LANE_W'(b) - a0;
      pos = {1'b0, a0} + {1'b0, off};
      lanes[b].en    = {1'b0, off} < len;
      lanes[b].row   = row0 + brq_pkg::ROW_W'(pos[brq_pkg::LANE_W]);
      lanes[b].wbyte = data[off*8 +: 8];
    end
  end

endmodule

// ===== sv/brq_bank_ram.sv =====
module brq_bank_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic                      re,
  input  logic [brq_pkg::ROW_W-1:0] addr,
  input  logic [7:0]                wdata,
  output logic [7:0]                rdata
);

  logic [7:0] mem [brq_pkg::BANK_ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== sv/brq_pop_align.sv =====
module brq_pop_align (
  input  logic [7:0]                 bank_data [brq_pkg::NUM_BANKS],
  input  brq_pkg::pop_info_t         info,
  output logic [brq_pkg::DATA_W-1:0] value
);

  logic [brq_pkg::LEN_W-1:0] len;

  assign len = brq_pkg::size_len(info.size);

  // Byte i of the result came from bank (a0 + i); bytes beyond the length read zero.
  always_comb begin
    logic [brq_pkg::LANE_W-1:0] idx;
    for (int i = 0; i < brq_pkg::NUM_BANKS; i++) begin
      idx = info.a0 + brq_pkg::LANE_W'(i);
      value[i*8 +: 8] = (brq_pkg::LEN_W'(i) < len) ? bank_data[idx] : 8'h00;
    end
  end

endmodule

// ===== sv/byte_ring_queue_multiwidth.sv =====
// The bank read happens at the edge that accepts a pop; the aligned result moves
// from stage s1 into the output register once the output can take it; a push gives no result.
// Throughput: one item per cycle, set by the single port of each of the eight
// byte-wide banks; the input stalls only while the output is held.
// Reset clears both pointers, loads capacity 4088 and empties the pipeline;
// the byte store is not cleared.
module byte_ring_queue_multiwidth (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [brq_pkg::CAP_W-1:0] cfg_data,
  brq_req_if.sink                   req,
  brq_rsp_if.source                 rsp
);

  logic [brq_pkg::PTR_W-1:0] wr_ptr;
  logic [brq_pkg::PTR_W-1:0] rd_ptr;
  logic [brq_pkg::CAP_W-1:0] cap;

  logic                      s1_valid;
  brq_pkg::pop_info_t        s1_info;
  logic                      out_valid;
  logic [brq_pkg::DATA_W-1:0] pop_data;

  logic                      accept;
  logic                      is_pop;
  logic                      s1_move;
  logic [brq_pkg::PTR_W-1:0] base;
  logic [brq_pkg::PTR_W:0]   ptr_sum;
  logic [brq_pkg::PTR_W-1:0] ptr_next;

  brq_pkg::lane_t            lanes [brq_pkg::NUM_BANKS];
  logic [7:0]                bank_data [brq_pkg::NUM_BANKS];
  logic [brq_pkg::DATA_W-1:0] aligned;

  assign s1_move   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_move;
  assign accept    = req.valid && req.ready;
  assign is_pop    = req.func == brq_pkg::FUNC_POP;
  assign base      = is_pop ? rd_ptr : wr_ptr;

  // The pointer returns to zero once it reaches or passes the capacity.
  assign ptr_sum  = {1'b0, base} + (brq_pkg::PTR_W + 1)'(brq_pkg::size_len(req.access_size));
  assign ptr_next = (ptr_sum >= (brq_pkg::PTR_W + 1)'(cap)) ? '0 : ptr_sum[brq_pkg::PTR_W-1:0];

  brq_lane_map u_lane_map (
    .base  (base),
    .size  (req.access_size),
    .data  (req.push_data),
    .lanes (lanes)
  );

  for (genvar b = 0; b < brq_pkg::NUM_BANKS; b++) begin : g_bank
    brq_bank_ram u_bank (
      .clk   (clk),
      .we    (accept && !is_pop && lanes[b].en),
      .re    (accept && is_pop && lanes[b].en),
      .addr  (lanes[b].row),
      .wdata (lanes[b].wbyte),
      .rdata (bank_data[b])
    );
  end

  brq_pop_align u_pop_align (
    .bank_data (bank_data),
    .info      (s1_info),
    .value     (aligned)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      cap       <= brq_pkg::CAP_RESET;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap <= cfg_data;
      end
      if (accept) begin
        if (is_pop) begin
          rd_ptr <= ptr_next;
        end else begin
          wr_ptr <= ptr_next;
        end
      end
      if (accept) begin
        s1_valid <= is_pop;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_pop) begin
      s1_info.a0   <= brq_pkg::LANE_W'(brq_pkg::ADDR_W'(rd_ptr));
      s1_info.size <= req.access_size;
    end
    if (s1_move) begin
      pop_data <= aligned;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.pop_data = pop_data;

endmodule
